[hw/rtl/tfns_pkg.sv]
// tfns_pkg: shared types and codes for the triangle face normal block.
// Item and result structs, request and status codes, controller commands.
// No dependencies.
package tfns_pkg;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [15:0]        vertex_index;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] pos_z;
		logic [15:0]        corner_a;
		logic [15:0]        corner_b;
		logic [15:0]        corner_c;
	} tfns_in_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
		logic signed [15:0] read_x;
		logic signed [15:0] read_y;
		logic signed [15:0] read_z;
	} tfns_out_t;

	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_TRI   = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_DEGEN = 2'd2;

	localparam logic [3:0] OP_NONE      = 4'd0;
	localparam logic [3:0] OP_LOAD      = 4'd1;
	localparam logic [3:0] OP_POS_WR    = 4'd2;
	localparam logic [3:0] OP_RD        = 4'd3;
	localparam logic [3:0] OP_EDGE      = 4'd4;
	localparam logic [3:0] OP_MUL       = 4'd5;
	localparam logic [3:0] OP_MAG       = 4'd6;
	localparam logic [3:0] OP_SQ        = 4'd7;
	localparam logic [3:0] OP_SQRT_INIT = 4'd8;
	localparam logic [3:0] OP_SQRT      = 4'd9;
	localparam logic [3:0] OP_DIV_INIT  = 4'd10;
	localparam logic [3:0] OP_DIV       = 4'd11;
	localparam logic [3:0] OP_NRM_WR    = 4'd12;
	localparam logic [3:0] OP_CLEAR     = 4'd13;
	localparam logic [3:0] OP_RESP      = 4'd14;

	localparam logic [1:0] SEL_VI = 2'd0;
	localparam logic [1:0] SEL_A  = 2'd1;
	localparam logic [1:0] SEL_B  = 2'd2;
	localparam logic [1:0] SEL_C  = 2'd3;

	typedef struct packed {
		logic [3:0] op;
		logic [1:0] sel;
		logic [4:0] step;
	} tfns_cmd_t;

	typedef struct packed {
		logic [1:0] req;
		logic       vi_oor;
		logic       corner_oor;
		logic       degen;
		logic       clr_last;
	} tfns_stat_t;

endpackage

[hw/rtl/tfns_datapath.sv]
// tfns_datapath: vertex stores, cross product, square root and divide units.
// Driven by tfns_ctrl commands; depends on tfns_pkg.
module tfns_datapath #(
	parameter int MAX_VERTICES = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tfns_pkg::tfns_in_t   in_data,
	input  logic                 cfg_we,
	input  logic [12:0]          cfg_wdata,
	input  tfns_pkg::tfns_cmd_t  cmd,
	output tfns_pkg::tfns_stat_t stat,
	output tfns_pkg::tfns_out_t  out_data
);

	localparam int AW = $clog2(MAX_VERTICES);
	localparam logic [16:0] MAXV = 17'(MAX_VERTICES);
	localparam logic [AW-1:0] LAST_ADR = AW'(MAX_VERTICES - 1);

	tfns_pkg::tfns_in_t  item_q;
	tfns_pkg::tfns_out_t out_q;
	tfns_pkg::tfns_out_t res_d;
	logic [12:0] vc_q;

	logic [47:0] pos_mem [MAX_VERTICES];
	logic [47:0] nrm_mem [MAX_VERTICES];
	logic [47:0] pos_rd_q, nrm_rd_q;
	logic        rd_v_s1;
	logic [1:0]  rd_sel_s1;
	logic [47:0] pa_q, pb_q, pc_q;

	logic signed [16:0] e1_q [3];
	logic signed [16:0] e2_q [3];
	logic signed [16:0] ma, mb;
	logic signed [33:0] prod_s1;
	logic        prod_v_s1;
	logic [2:0]  prod_tag_s1;
	logic signed [33:0] c_q [3];

	logic [33:0] am [3];
	logic [33:0] orm;
	logic [2:0]  sh;
	logic [29:0] mag_q [3];
	logic [2:0]  neg_q;
	logic [59:0] sq_s1;
	logic        sq_v_s1;
	logic [61:0] sum_q;

	logic [62:0] x_q, res_q, bit_q, sq_t;
	logic [45:0] num_q;
	logic [44:0] den_q;
	logic [14:0] quo_q;
	logic        ge;
	logic signed [15:0] n_q [3];

	logic [AW-1:0] clr_q;
	logic [AW-1:0] sel_adr, vi_adr, nrm_wadr;
	logic [16:0]   limit;
	logic          vi_oor, corner_oor, degen;
	logic          pos_we, nrm_we;
	logic [47:0]   nrm_wd;

	function automatic logic signed [16:0] comp(input logic [47:0] v, input int k);
		logic [15:0] t;
		t = v[47-16*k -: 16];
		return {t[15], t};
	endfunction

	assign vi_adr = item_q.vertex_index[AW-1:0];
	assign limit  = ({4'b0, vc_q} < MAXV) ? {4'b0, vc_q} : MAXV;
	assign vi_oor = {1'b0, item_q.vertex_index} >= MAXV;
	assign corner_oor = ({1'b0, item_q.corner_a} >= limit) ||
		({1'b0, item_q.corner_b} >= limit) || ({1'b0, item_q.corner_c} >= limit);
	assign degen = (c_q[0] == '0) && (c_q[1] == '0) && (c_q[2] == '0);

	always_comb begin
		unique case (cmd.sel)
			tfns_pkg::SEL_VI: sel_adr = vi_adr;
			tfns_pkg::SEL_A:  sel_adr = item_q.corner_a[AW-1:0];
			tfns_pkg::SEL_B:  sel_adr = item_q.corner_b[AW-1:0];
			default:          sel_adr = item_q.corner_c[AW-1:0];
		endcase
	end

	assign pos_we   = (cmd.op == tfns_pkg::OP_POS_WR) && !vi_oor;
	assign nrm_we   = (cmd.op == tfns_pkg::OP_CLEAR) || (cmd.op == tfns_pkg::OP_NRM_WR);
	assign nrm_wadr = (cmd.op == tfns_pkg::OP_CLEAR) ? clr_q : sel_adr;
	assign nrm_wd   = (cmd.op == tfns_pkg::OP_CLEAR) ? 48'd0 : {n_q[0], n_q[1], n_q[2]};

	always_ff @(posedge clk) begin
		if (pos_we)
			pos_mem[vi_adr] <= {item_q.pos_x, item_q.pos_y, item_q.pos_z};
		if (cmd.op == tfns_pkg::OP_RD)
			pos_rd_q <= pos_mem[sel_adr];
	end

	always_ff @(posedge clk) begin
		if (nrm_we)
			nrm_mem[nrm_wadr] <= nrm_wd;
		if (cmd.op == tfns_pkg::OP_RD)
			nrm_rd_q <= nrm_mem[sel_adr];
	end

	// cross product: c0 = e1y*e2z - e1z*e2y, c1 = e1z*e2x - e1x*e2z, c2 = e1x*e2y - e1y*e2x
	always_comb begin
		case (cmd.step[2:0])
			3'd0: begin ma = e1_q[1]; mb = e2_q[2]; end
			3'd1: begin ma = e1_q[2]; mb = e2_q[1]; end
			3'd2: begin ma = e1_q[2]; mb = e2_q[0]; end
			3'd3: begin ma = e1_q[0]; mb = e2_q[2]; end
			3'd4: begin ma = e1_q[0]; mb = e2_q[1]; end
			default: begin ma = e1_q[1]; mb = e2_q[0]; end
		endcase
	end

	always_comb begin
		for (int k = 0; k < 3; k++)
			am[k] = c_q[k][33] ? 34'(-c_q[k]) : 34'(c_q[k]);
		orm = am[0] | am[1] | am[2];
		if (orm[33])      sh = 3'd4;
		else if (orm[32]) sh = 3'd3;
		else if (orm[31]) sh = 3'd2;
		else if (orm[30]) sh = 3'd1;
		else              sh = 3'd0;
	end

	assign sq_t = res_q + bit_q;
	assign ge   = num_q >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q      <= '0;
			rd_v_s1   <= 1'b0;
			prod_v_s1 <= 1'b0;
			sq_v_s1   <= 1'b0;
			clr_q     <= '0;
		end else begin
			if (cfg_we)
				vc_q <= cfg_wdata;
			rd_v_s1   <= cmd.op == tfns_pkg::OP_RD;
			prod_v_s1 <= (cmd.op == tfns_pkg::OP_MUL) && (cmd.step < 5'd6);
			sq_v_s1   <= (cmd.op == tfns_pkg::OP_SQ) && (cmd.step < 5'd3);
			if (cmd.op == tfns_pkg::OP_CLEAR)
				clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == tfns_pkg::OP_LOAD)
			item_q <= in_data;
		rd_sel_s1 <= cmd.sel;
		if (rd_v_s1) begin
			unique case (rd_sel_s1)
				tfns_pkg::SEL_A: pa_q <= pos_rd_q;
				tfns_pkg::SEL_B: pb_q <= pos_rd_q;
				tfns_pkg::SEL_C: pc_q <= pos_rd_q;
				default: ;
			endcase
		end
		if (cmd.op == tfns_pkg::OP_EDGE) begin
			for (int k = 0; k < 3; k++) begin
				e1_q[k] <= comp(pb_q, k) - comp(pa_q, k);
				e2_q[k] <= comp(pc_q, k) - comp(pa_q, k);
				c_q[k]  <= '0;
				n_q[k]  <= '0;
			end
		end
		prod_s1     <= ma * mb;
		prod_tag_s1 <= cmd.step[2:0];
		if (prod_v_s1) begin
			if (prod_tag_s1[0])
				c_q[prod_tag_s1[2:1]] <= c_q[prod_tag_s1[2:1]] - prod_s1;
			else
				c_q[prod_tag_s1[2:1]] <= c_q[prod_tag_s1[2:1]] + prod_s1;
		end
		if (cmd.op == tfns_pkg::OP_MAG) begin
			for (int k = 0; k < 3; k++) begin
				mag_q[k] <= 30'(am[k] >> sh);
				neg_q[k] <= c_q[k][33];
			end
			sum_q <= '0;
		end
		sq_s1 <= mag_q[cmd.step[1:0]] * mag_q[cmd.step[1:0]];
		if (sq_v_s1)
			sum_q <= sum_q + 62'(sq_s1);
		if (cmd.op == tfns_pkg::OP_SQRT_INIT) begin
			x_q   <= {1'b0, sum_q};
			res_q <= '0;
			bit_q <= 63'(1) << 62;
		end
		if (cmd.op == tfns_pkg::OP_SQRT) begin
			if (x_q >= sq_t) begin
				x_q   <= x_q - sq_t;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (cmd.op == tfns_pkg::OP_DIV_INIT) begin
			num_q <= {2'b0, mag_q[cmd.sel], 14'b0} + 46'(res_q[30:1]);
			den_q <= {res_q[30:0], 14'b0};
			quo_q <= '0;
		end
		if (cmd.op == tfns_pkg::OP_DIV) begin
			if (cmd.step == 5'd15) begin
				n_q[cmd.sel] <= neg_q[cmd.sel] ? -16'({1'b0, quo_q}) : 16'({1'b0, quo_q});
			end else begin
				if (ge)
					num_q <= num_q - {1'b0, den_q};
				quo_q <= {quo_q[13:0], ge};
				den_q <= den_q >> 1;
			end
		end
		if (cmd.op == tfns_pkg::OP_RESP)
			out_q <= res_d;
	end

	always_comb begin
		res_d = '0;
		case (item_q.req_type)
			tfns_pkg::REQ_WRITE: res_d.status = vi_oor ? tfns_pkg::ST_RANGE : tfns_pkg::ST_DONE;
			tfns_pkg::REQ_READ: begin
				if (vi_oor) begin
					res_d.status = tfns_pkg::ST_RANGE;
				end else begin
					{res_d.normal_x, res_d.normal_y, res_d.normal_z} = nrm_rd_q;
					{res_d.read_x, res_d.read_y, res_d.read_z} = pos_rd_q;
				end
			end
			tfns_pkg::REQ_TRI: begin
				if (corner_oor)
					res_d.status = tfns_pkg::ST_RANGE;
				else if (degen)
					res_d.status = tfns_pkg::ST_DEGEN;
				else begin
					res_d.normal_x = n_q[0];
					res_d.normal_y = n_q[1];
					res_d.normal_z = n_q[2];
				end
			end
			default: ;
		endcase
	end

	assign stat.req        = item_q.req_type;
	assign stat.vi_oor     = vi_oor;
	assign stat.corner_oor = corner_oor;
	assign stat.degen      = degen;
	assign stat.clr_last   = clr_q == LAST_ADR;
	assign out_data        = out_q;

endmodule

[hw/rtl/tfns_ctrl.sv]
// tfns_ctrl: sequencing state machine for the triangle face normal block.
// Issues tfns_cmd_t to tfns_datapath and owns the handshakes; uses tfns_pkg.
module tfns_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  tfns_pkg::tfns_stat_t stat,
	output tfns_pkg::tfns_cmd_t  cmd
);

	localparam logic [4:0] S_CLEAR = 5'd0;
	localparam logic [4:0] S_IDLE  = 5'd1;
	localparam logic [4:0] S_DISP  = 5'd2;
	localparam logic [4:0] S_RD_A  = 5'd3;
	localparam logic [4:0] S_RD_B  = 5'd4;
	localparam logic [4:0] S_RD_C  = 5'd5;
	localparam logic [4:0] S_RD_W  = 5'd6;
	localparam logic [4:0] S_EDGE  = 5'd7;
	localparam logic [4:0] S_MUL   = 5'd8;
	localparam logic [4:0] S_MAG   = 5'd9;
	localparam logic [4:0] S_SQ    = 5'd10;
	localparam logic [4:0] S_SQI   = 5'd11;
	localparam logic [4:0] S_SQRT  = 5'd12;
	localparam logic [4:0] S_DVI   = 5'd13;
	localparam logic [4:0] S_DIV   = 5'd14;
	localparam logic [4:0] S_NW_A  = 5'd15;
	localparam logic [4:0] S_NW_B  = 5'd16;
	localparam logic [4:0] S_NW_C  = 5'd17;
	localparam logic [4:0] S_RESP  = 5'd18;

	logic [4:0] state_q, state_d;
	logic [4:0] step_q, step_d;
	logic [1:0] comp_q, comp_d;
	logic       out_valid_q;
	logic       fire;

	assign fire = !out_valid_q || out_ready;

	always_comb begin
		state_d  = state_q;
		step_d   = step_q;
		comp_d   = comp_q;
		cmd.op   = tfns_pkg::OP_NONE;
		cmd.sel  = tfns_pkg::SEL_VI;
		cmd.step = step_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.op = tfns_pkg::OP_CLEAR;
				if (stat.clr_last)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = tfns_pkg::OP_LOAD;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				state_d = S_RESP;
				case (stat.req)
					tfns_pkg::REQ_WRITE: cmd.op = tfns_pkg::OP_POS_WR;
					tfns_pkg::REQ_READ:  if (!stat.vi_oor) cmd.op = tfns_pkg::OP_RD;
					tfns_pkg::REQ_TRI:   if (!stat.corner_oor) state_d = S_RD_A;
					default: ;
				endcase
			end
			S_RD_A: begin
				cmd.op = tfns_pkg::OP_RD; cmd.sel = tfns_pkg::SEL_A; state_d = S_RD_B;
			end
			S_RD_B: begin
				cmd.op = tfns_pkg::OP_RD; cmd.sel = tfns_pkg::SEL_B; state_d = S_RD_C;
			end
			S_RD_C: begin
				cmd.op = tfns_pkg::OP_RD; cmd.sel = tfns_pkg::SEL_C; state_d = S_RD_W;
			end
			S_RD_W: state_d = S_EDGE;
			S_EDGE: begin
				cmd.op  = tfns_pkg::OP_EDGE;
				step_d  = '0;
				state_d = S_MUL;
			end
			S_MUL: begin
				cmd.op = tfns_pkg::OP_MUL;
				step_d = step_q + 1'b1;
				if (step_q == 5'd6)
					state_d = S_MAG;
			end
			S_MAG: begin
				cmd.op  = tfns_pkg::OP_MAG;
				step_d  = '0;
				state_d = stat.degen ? S_NW_A : S_SQ;
			end
			S_SQ: begin
				cmd.op = tfns_pkg::OP_SQ;
				step_d = step_q + 1'b1;
				if (step_q == 5'd3)
					state_d = S_SQI;
			end
			S_SQI: begin
				cmd.op  = tfns_pkg::OP_SQRT_INIT;
				step_d  = '0;
				state_d = S_SQRT;
			end
			S_SQRT: begin
				cmd.op = tfns_pkg::OP_SQRT;
				step_d = step_q + 1'b1;
				if (step_q == 5'd31) begin
					comp_d  = '0;
					state_d = S_DVI;
				end
			end
			S_DVI: begin
				cmd.op  = tfns_pkg::OP_DIV_INIT;
				cmd.sel = comp_q;
				step_d  = '0;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.op  = tfns_pkg::OP_DIV;
				cmd.sel = comp_q;
				step_d  = step_q + 1'b1;
				if (step_q == 5'd15) begin
					comp_d  = comp_q + 1'b1;
					state_d = (comp_q == 2'd2) ? S_NW_A : S_DVI;
				end
			end
			S_NW_A: begin
				cmd.op = tfns_pkg::OP_NRM_WR; cmd.sel = tfns_pkg::SEL_A; state_d = S_NW_B;
			end
			S_NW_B: begin
				cmd.op = tfns_pkg::OP_NRM_WR; cmd.sel = tfns_pkg::SEL_B; state_d = S_NW_C;
			end
			S_NW_C: begin
				cmd.op = tfns_pkg::OP_NRM_WR; cmd.sel = tfns_pkg::SEL_C; state_d = S_RESP;
			end
			S_RESP: begin
				if (fire) begin
					cmd.op  = tfns_pkg::OP_RESP;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			step_q      <= '0;
			comp_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			comp_q  <= comp_d;
			if (cmd.op == tfns_pkg::OP_RESP)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

[hw/rtl/triangle_face_normal_scatter.sv]
// triangle_face_normal_scatter: flat-shading face normals over a vertex store.
// Top level; instantiates tfns_ctrl and tfns_datapath, uses tfns_pkg.
//
// One item at a time. After reset the normal store is swept to zero, one entry
// per cycle, with in_ready low. A position write or read, or an out-of-range
// triangle, goes straight from dispatch to the response. A triangle runs three
// gathers, six products on one shared 17x17 multiplier, three squares, a
// 32-step square root, then three 16-step restoring divisions, and three normal
// writes (a degenerate triangle skips the squares, root and divisions). The
// result sits in an output register, so the next item can be accepted while it
// waits.
module triangle_face_normal_scatter #(
	parameter int MAX_VERTICES = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tfns_pkg::tfns_in_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output tfns_pkg::tfns_out_t out_data,
	input  logic                cfg_we,
	input  logic [12:0]         cfg_wdata
);

	tfns_pkg::tfns_cmd_t  cmd;
	tfns_pkg::tfns_stat_t stat;

	tfns_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	tfns_datapath #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.stat      (stat),
		.out_data  (out_data)
	);

`ifndef SYNTHESIS
	a_load_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |-> (cmd.op == tfns_pkg::OP_LOAD))
		else $error("beat accepted without item load");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("ready held after accept");

	a_resp_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == tfns_pkg::OP_RESP) |=> out_valid)
		else $error("result load without out_valid");
`endif

endmodule
